@@ hw/rtl/reaction_timer_controller_macros.svh @@
// assertion macros for the reaction timer controller
`ifndef REACTION_TIMER_CONTROLLER_MACROS_SVH
`define REACTION_TIMER_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// implication in the same cycle
`define RTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// implication in the next cycle
`define RTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define RTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/rtc_pkg.sv @@
// shared types, constants and helper functions of the reaction timer controller
package rtc_pkg;

	localparam int TIME_WIDTH = 16;
	localparam int REG_W      = 16;
	localparam int CMP_W      = (TIME_WIDTH > REG_W) ? TIME_WIDTH : REG_W;
	localparam int RAND_W     = 32;
	localparam int CNT_W      = $clog2(RAND_W);
	localparam int IDX_W      = 3;

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic [REG_W-1:0]      reg_t;

	localparam time_t TIME_MAX = '1;
	localparam reg_t  REG_MAX  = '1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_DEBOUNCE = 3'd0;
	localparam logic [IDX_W-1:0] REG_WAIT_MIN = 3'd1;
	localparam logic [IDX_W-1:0] REG_WAIT_MAX = 3'd2;
	localparam logic [IDX_W-1:0] REG_SETTLE   = 3'd3;
	localparam logic [IDX_W-1:0] REG_TIMEOUT  = 3'd4;
	localparam logic [IDX_W-1:0] REG_MSG_HOLD = 3'd5;
	localparam logic [IDX_W-1:0] REG_RES_HOLD = 3'd6;

	// reset values
	localparam reg_t RST_DEBOUNCE = 16'd50;
	localparam reg_t RST_WAIT_MIN = 16'd1000;
	localparam reg_t RST_WAIT_MAX = 16'd4000;
	localparam reg_t RST_SETTLE   = 16'd150;
	localparam reg_t RST_TIMEOUT  = 16'd2000;
	localparam reg_t RST_MSG_HOLD = 16'd2000;
	localparam reg_t RST_RES_HOLD = 16'd3000;

	typedef struct packed {
		reg_t debounce_ms;
		reg_t wait_lo_ms;
		reg_t wait_hi_ms;
		reg_t settle_ms;
		reg_t react_limit_ms;
		reg_t message_hold_ms;
		reg_t result_hold_ms;
	} cfg_t;

	// saturating increment
	function automatic time_t sat_inc(time_t v);
		return (v == TIME_MAX) ? TIME_MAX : v + time_t'(1);
	endfunction

	// count reached a limit, limit clamped to the counter maximum
	function automatic logic reached(time_t t, reg_t lim);
		return (CMP_W'(t) >= CMP_W'(lim)) || (t == TIME_MAX);
	endfunction

	// count clipped to the width of the reaction time
	function automatic reg_t clip_reaction(time_t t);
		if (CMP_W'(t) > CMP_W'(REG_MAX)) begin
			return REG_MAX;
		end
		return REG_W'(t);
	endfunction

endpackage

@@ hw/rtl/reaction_timer_controller.sv @@
// top level of the reaction timer controller: phase sequencer, debounce and result register
//
// One tick beat is one millisecond of the tester. Each accepted beat advances
// the debounce counter and the phase sequencer, and its result beat (led,
// phase code, last reaction time, result pulse) appears in the output register
// on the next cycle. A tick is normally taken every cycle while the result
// side keeps up. On the tick that closes the settle window, the random wait is
// drawn by a bit-serial remainder unit working one random bit per cycle, so
// the following tick is held off by tick_stall until the draw is done. The
// result register holds a beat until the consumer takes it; a new tick is
// taken in the same cycle the old result leaves. Configuration is written
// through cfg_we, cfg_index and cfg_data; writes to an index past the
// register list are dropped.
`include "reaction_timer_controller_macros.svh"

module reaction_timer_controller (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write port
	input  logic                       cfg_we,
	input  logic [rtc_pkg::IDX_W-1:0]  cfg_index,
	input  logic [rtc_pkg::REG_W-1:0]  cfg_data,
	// tick channel
	input  logic                       tick_valid,
	output logic                       tick_stall,
	input  logic                       press_edge,
	input  logic [rtc_pkg::RAND_W-1:0] random_value,
	// result channel
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic                       led_on,
	output logic [2:0]                 phase_code,
	output logic [rtc_pkg::REG_W-1:0]  react_ms,
	output logic                       result_pulse
);
	import rtc_pkg::*;

	// phase codes
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_WAIT   = 3'd1;
	localparam logic [2:0] PH_REACT  = 3'd2;
	localparam logic [2:0] PH_EARLY  = 3'd3;
	localparam logic [2:0] PH_LATE   = 3'd4;
	localparam logic [2:0] PH_RESULT = 3'd5;

	cfg_t cfg;

	// sequencer state
	logic [2:0] phase_q;
	time_t      timer_q;
	time_t      since_q;
	logic       in_settle_q;
	reg_t       latched_q;

	// result register
	logic       res_valid_q;
	logic       led_q;
	logic [2:0] code_q;
	reg_t       react_q;
	logic       pulse_q;

	// draw unit
	logic draw_start;
	logic draw_busy;
	reg_t drawn_wait;

	logic tick_acc;

	// next-state values
	logic [2:0] phase_d;
	time_t      timer_d;
	time_t      since_d;
	logic       in_settle_d;
	reg_t       latched_d;
	logic       pulse_d;
	logic       press_ok;
	time_t      since_inc;
	time_t      timer_inc;

	rtc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rtc_wait_draw u_draw (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (draw_start),
		.random_value (random_value),
		.wait_min     (cfg.wait_lo_ms),
		.wait_max     (cfg.wait_hi_ms),
		.busy         (draw_busy),
		.drawn_wait   (drawn_wait)
	);

	// hold ticks while a draw runs or a result beat is still waiting
	assign tick_stall = draw_busy | (res_valid_q & res_stall);
	assign tick_acc   = tick_valid & ~tick_stall;

	always_comb begin
		since_inc   = sat_inc(since_q);
		timer_inc   = sat_inc(timer_q);
		// debounce runs on every tick, whatever the phase
		press_ok    = press_edge && (CMP_W'(since_inc) >= CMP_W'(cfg.debounce_ms));
		since_d     = press_ok ? '0 : since_inc;
		phase_d     = phase_q;
		timer_d     = timer_q;
		in_settle_d = in_settle_q;
		latched_d   = latched_q;
		pulse_d     = 1'b0;
		draw_start  = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (press_ok) begin
					phase_d     = PH_WAIT;
					timer_d     = '0;
					in_settle_d = 1'b1;
				end
			end
			PH_WAIT: begin
				if (in_settle_q) begin
					// presses in the settle window are dropped
					timer_d = timer_inc;
					if (reached(timer_inc, cfg.settle_ms)) begin
						draw_start  = tick_acc;
						in_settle_d = 1'b0;
						timer_d     = '0;
					end
				end else if (press_ok) begin
					phase_d = PH_EARLY;
					timer_d = '0;
				end else begin
					timer_d = timer_inc;
					if (reached(timer_inc, drawn_wait)) begin
						phase_d = PH_REACT;
						timer_d = '0;
					end
				end
			end
			PH_REACT: begin
				// count includes the tick of the press
				timer_d = timer_inc;
				if (press_ok) begin
					latched_d = clip_reaction(timer_inc);
					pulse_d   = 1'b1;
					phase_d   = PH_RESULT;
					timer_d   = '0;
				end else if (reached(timer_inc, cfg.react_limit_ms)) begin
					phase_d = PH_LATE;
					timer_d = '0;
				end
			end
			PH_EARLY, PH_LATE: begin
				timer_d = timer_inc;
				if (reached(timer_inc, cfg.message_hold_ms)) begin
					phase_d = PH_IDLE;
					timer_d = '0;
				end
			end
			PH_RESULT: begin
				timer_d = timer_inc;
				if (reached(timer_inc, cfg.result_hold_ms)) begin
					phase_d = PH_IDLE;
					timer_d = '0;
				end
			end
			default: begin
				phase_d     = PH_IDLE;
				timer_d     = '0;
				in_settle_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			timer_q     <= '0;
			since_q     <= TIME_MAX;
			in_settle_q <= 1'b0;
			latched_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (tick_acc) begin
				phase_q     <= phase_d;
				timer_q     <= timer_d;
				since_q     <= since_d;
				in_settle_q <= in_settle_d;
				latched_q   <= latched_d;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload, shows the state after the tick
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			led_q   <= (phase_d == PH_REACT);
			code_q  <= phase_d;
			react_q <= latched_d;
			pulse_q <= pulse_d;
		end
	end

	assign res_valid    = res_valid_q;
	assign led_on       = led_q;
	assign phase_code   = code_q;
	assign react_ms     = react_q;
	assign result_pulse = pulse_q;

	// no tick may slip in while the wait is being drawn
	`RTC_ASSERT_IMP(a_stall_in_draw, clk, arst_n, draw_busy, tick_stall)
	// an accepted tick always leaves a result beat behind
	`RTC_ASSERT_NXT(a_tick_gives_beat, clk, arst_n, tick_acc, res_valid)
	// a draw only starts when the settle window closes
	`RTC_ASSERT_NXT(a_draw_after_settle, clk, arst_n, draw_start,
		(phase_q == PH_WAIT) && !in_settle_q && draw_busy)
	// a result pulse only comes with the result phase
	`RTC_ASSERT_IMP(a_pulse_phase, clk, arst_n, res_valid && result_pulse,
		(phase_code == PH_RESULT) && !led_on)

endmodule

@@ hw/rtl/rtc_cfg_regs.sv @@
// configuration register file of the reaction timer controller
module rtc_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rtc_pkg::IDX_W-1:0]  cfg_index,
	input  logic [rtc_pkg::REG_W-1:0]  cfg_data,
	output rtc_pkg::cfg_t              cfg
);
	import rtc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= RST_DEBOUNCE;
			cfg_q.wait_lo_ms      <= RST_WAIT_MIN;
			cfg_q.wait_hi_ms      <= RST_WAIT_MAX;
			cfg_q.settle_ms       <= RST_SETTLE;
			cfg_q.react_limit_ms  <= RST_TIMEOUT;
			cfg_q.message_hold_ms <= RST_MSG_HOLD;
			cfg_q.result_hold_ms  <= RST_RES_HOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ms     <= cfg_data;
				REG_WAIT_MIN: cfg_q.wait_lo_ms      <= cfg_data;
				REG_WAIT_MAX: cfg_q.wait_hi_ms      <= cfg_data;
				REG_SETTLE:   cfg_q.settle_ms       <= cfg_data;
				REG_TIMEOUT:  cfg_q.react_limit_ms  <= cfg_data;
				REG_MSG_HOLD: cfg_q.message_hold_ms <= cfg_data;
				REG_RES_HOLD: cfg_q.result_hold_ms  <= cfg_data;
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/rtc_wait_draw.sv @@
// bit-serial random wait draw: min plus random modulo (span+1)
module rtc_wait_draw (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rtc_pkg::RAND_W-1:0] random_value,
	input  logic [rtc_pkg::REG_W-1:0]  wait_min,
	input  logic [rtc_pkg::REG_W-1:0]  wait_max,
	output logic                       busy,
	output logic [rtc_pkg::REG_W-1:0]  drawn_wait
);
	import rtc_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAND_W-1:0] shr_q;
	logic [REG_W:0]    div_q;
	reg_t              rem_q;
	reg_t              lo_q;
	reg_t              wait_q;

	reg_t           span;
	logic [REG_W:0] trial;
	reg_t           rem_next;

	assign span = (wait_max >= wait_min) ? wait_max - wait_min : '0;

	// one dividend bit per cycle, msb first
	always_comb begin
		trial = {rem_q, shr_q[RAND_W-1]};
		if (trial >= div_q) begin
			rem_next = REG_W'(trial - div_q);
		end else begin
			rem_next = REG_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			wait_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(RAND_W - 1)) begin
				busy_q <= 1'b0;
				wait_q <= lo_q + rem_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shr_q <= random_value;
			div_q <= {1'b0, span} + (REG_W+1)'(1);
			rem_q <= '0;
			lo_q  <= wait_min;
		end else if (busy_q) begin
			shr_q <= {shr_q[RAND_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign busy       = busy_q;
	assign drawn_wait = wait_q;

endmodule
